### rtl/search_result_table_core_assert.svh
// Assertion macros shared by the search result table modules.
// Each check runs on the rising edge of clk and is off while rst is high.
`ifndef SEARCH_RESULT_TABLE_CORE_ASSERT_SVH
`define SEARCH_RESULT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/srt_pkg.sv
`default_nettype none

package srt_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic KIND_PROBE  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [7:0]  depth;
    logic [1:0]         bound;
    logic signed [15:0] score;
    logic [31:0]        move;
  } slot_t;

  localparam slot_t SLOT_RESET = '{
    key:   64'd0,
    depth: -8'sd1,
    bound: BOUND_UPPER,
    score: 16'sd0,
    move:  32'd0
  };

  // controller to datapath
  typedef struct packed {
    logic clear;  // write the reset word at the sweep address, advance it
    logic load;   // capture the incoming beat
    logic eval;   // slot word is ready: decide, write back a record, emit a probe result
  } srt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep address is at the last slot
  } srt_stat_t;

endpackage

`default_nettype wire

### rtl/srt_ctrl.sv
`default_nettype none
`include "search_result_table_core_assert.svh"

module srt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire srt_pkg::srt_stat_t stat,
  output srt_pkg::srt_cmd_t      cmd,
  output logic                   busy
);
  import srt_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  state_t state;
  state_t state_next;
  logic   busy_next;

  always_comb begin
    state_next = state;
    busy_next  = busy;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next = ST_IDLE;
          busy_next  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_READ;
          busy_next  = 1'b1;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_IDLE;
        busy_next  = 1'b0;
      end
      default: begin
        state_next = ST_CLEAR;
        busy_next  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= busy_next;
    end
  end

  assign cmd.clear = (state == ST_CLEAR);
  assign cmd.load  = (state == ST_IDLE) && start;
  assign cmd.eval  = (state == ST_EVAL);

  `SRT_ASSERT_NOW(a_idle_when_free, !busy, state == ST_IDLE, "not busy outside idle")
  `SRT_ASSERT_NEXT(a_read_to_eval, state == ST_READ, state == ST_EVAL, "read not followed by eval")
  `SRT_ASSERT_NEXT(a_eval_frees, state == ST_EVAL, !busy && state == ST_IDLE, "eval did not free")

endmodule

`default_nettype wire

### rtl/srt_datapath.sv
`default_nettype none
`include "search_result_table_core_assert.svh"

module srt_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srt_pkg::srt_cmd_t  cmd,
  output srt_pkg::srt_stat_t      stat,
  input  wire logic               kind,
  input  wire logic [63:0]        position_hash,
  input  wire logic signed [7:0]  search_depth,
  input  wire logic signed [15:0] window_low,
  input  wire logic signed [15:0] window_high,
  input  wire logic [1:0]         bound_type,
  input  wire logic signed [15:0] result_score,
  input  wire logic [31:0]        result_move,
  output logic                    done,
  output logic                    key_hit,
  output logic [31:0]             hit_move,
  output logic                    score_known,
  output logic signed [15:0]      probe_score
);
  import srt_pkg::*;

  slot_t mem [TABLE_ENTRIES];

  logic               item_kind;
  logic [63:0]        item_hash;
  logic signed [7:0]  item_depth;
  logic signed [15:0] item_alpha;
  logic signed [15:0] item_beta;
  logic [1:0]         item_bound;
  logic signed [15:0] item_score;
  logic [31:0]        item_move;

  logic [IDX_W-1:0] clr_cnt;
  logic [IDX_W-1:0] idx;
  slot_t            rd_word;

  logic               same;
  logic               empty;
  logic               close;
  logic               deep;
  logic signed [9:0]  new_depth_x;
  logic signed [9:0]  old_depth_x;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  slot_t              wdata;
  logic               known;
  logic signed [15:0] known_score;

  assign idx             = item_hash[IDX_W-1:0];
  assign stat.clear_last = (clr_cnt == {IDX_W{1'b1}});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind  <= kind;
      item_hash  <= position_hash;
      item_depth <= search_depth;
      item_alpha <= window_low;
      item_beta  <= window_high;
      item_bound <= bound_type;
      item_score <= result_score;
      item_move  <= result_move;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // replacement test and probe rules
  always_comb begin
    same        = (rd_word.key == item_hash);
    empty       = (rd_word.key == 64'd0);
    new_depth_x = $signed({{2{item_depth[7]}}, item_depth})
                  + $signed({9'd0, item_bound == BOUND_EXACT});
    old_depth_x = $signed({{2{rd_word.depth[7]}}, rd_word.depth}) - 10'sd1;
    close       = (new_depth_x >= old_depth_x);
    deep        = (rd_word.depth >= item_depth);

    known       = 1'b0;
    known_score = 16'sd0;
    if (same && deep) begin
      case (rd_word.bound)
        BOUND_EXACT: begin
          known       = 1'b1;
          known_score = rd_word.score;
        end
        BOUND_UPPER: begin
          if (rd_word.score <= item_alpha) begin
            known       = 1'b1;
            known_score = item_alpha;
          end
        end
        BOUND_LOWER: begin
          if (rd_word.score >= item_beta) begin
            known       = 1'b1;
            known_score = item_beta;
          end
        end
        default: begin
          known = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = SLOT_RESET;
    end else begin
      we          = cmd.eval && (item_kind == KIND_RECORD) && (empty || same || close);
      waddr       = idx;
      wdata.key   = item_hash;
      wdata.depth = item_depth;
      wdata.bound = item_bound;
      wdata.score = item_score;
      wdata.move  = item_move;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.eval && (item_kind == KIND_PROBE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && (item_kind == KIND_PROBE)) begin
      key_hit     <= same;
      hit_move    <= same ? rd_word.move : 32'd0;
      score_known <= known;
      probe_score <= known_score;
    end
  end

  `SRT_ASSERT_NOW(a_probe_no_write, cmd.eval && item_kind == KIND_PROBE, !we, "probe wrote table")
  `SRT_ASSERT_NOW(a_done_from_probe, done, $past(cmd.eval) && $past(item_kind) == KIND_PROBE, "stray result")
  `SRT_ASSERT_NEXT(a_sweep_step, cmd.clear, clr_cnt == $past(clr_cnt) + 1'b1, "sweep did not advance")

endmodule

`default_nettype wire

### rtl/search_result_table_core.sv
`default_nettype none

// Direct-mapped table of search results, 4096 slots chosen by the low hash
// bits. After reset the block sweeps every slot back to its empty contents,
// one slot a cycle, so busy stays high until the sweep is done and the first
// beat can be taken. A beat is taken on a clock edge with start high and busy
// low; busy then stays high through the read and eval states while the slot
// is read from the table memory and the probe or record is decided, so no new
// beat is taken before the last one is through. A probe produces exactly one
// result: done is registered in the eval state and is high for one cycle,
// together with key_hit, hit_move, score_known and probe_score. A record
// produces no result. The receiver cannot stall: take the result in the
// cycle done is high, it is gone after that.
module search_result_table_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               kind,
  input  wire logic [63:0]        position_hash,
  input  wire logic signed [7:0]  search_depth,
  input  wire logic signed [15:0] window_low,
  input  wire logic signed [15:0] window_high,
  input  wire logic [1:0]         bound_type,
  input  wire logic signed [15:0] result_score,
  input  wire logic [31:0]        result_move,
  output logic                    done,
  output logic                    key_hit,
  output logic [31:0]             hit_move,
  output logic                    score_known,
  output logic signed [15:0]      probe_score
);
  import srt_pkg::*;

  // command and status between sequencer and slot datapath
  srt_cmd_t  cmd;
  srt_stat_t stat;

  // sequencer: reset sweep, then read, decide, back to idle for each beat
  srt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: beat capture, table memory, replacement test, probe rules
  srt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .kind          (kind),
    .position_hash (position_hash),
    .search_depth  (search_depth),
    .window_low    (window_low),
    .window_high   (window_high),
    .bound_type    (bound_type),
    .result_score  (result_score),
    .result_move   (result_move),
    .done          (done),
    .key_hit       (key_hit),
    .hit_move      (hit_move),
    .score_known   (score_known),
    .probe_score   (probe_score)
  );

endmodule

`default_nettype wire

### bench/srt_probe_checker.sv
// Watches the beat and result channels of the search result table, keeps a
// mirror of the slot contents and checks every probe result in order.
module srt_probe_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               kind,
  input  logic [63:0]        position_hash,
  input  logic signed [7:0]  search_depth,
  input  logic signed [15:0] window_low,
  input  logic signed [15:0] window_high,
  input  logic [1:0]         bound_type,
  input  logic signed [15:0] result_score,
  input  logic [31:0]        result_move,
  input  logic               done,
  input  logic               key_hit,
  input  logic [31:0]        hit_move,
  input  logic               score_known,
  input  logic signed [15:0] probe_score,
  output int                 mismatches,
  output int                 pending
);

  import srt_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [31:0]        move;
    logic               known;
    logic signed [15:0] score;
  } probe_reply_t;

  slot_t        table_mirror [TABLE_ENTRIES];
  probe_reply_t replies_due [$];
  int           mismatch_total = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk) begin : watch
    slot_t        s;
    probe_reply_t r;
    int           new_rank;
    int           old_rank;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) table_mirror[i] = SLOT_RESET;
      replies_due.delete();
    end else begin
      // Results first: a new beat can be taken on the edge that ends a result.
      if (done === 1'b1) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result", {63'd0, done}, 64'd0);
        end else begin
          r = replies_due.pop_front();
          if (key_hit !== r.hit) report_mismatch("key_hit", key_hit, r.hit);
          if (hit_move !== r.move) report_mismatch("hit_move", hit_move, r.move);
          if (score_known !== r.known)
            report_mismatch("score_known", score_known, r.known);
          if (probe_score !== r.score)
            report_mismatch("probe_score", probe_score, r.score);
        end
      end
      if (start && busy === 1'b0) begin
        s = table_mirror[position_hash[IDX_W-1:0]];
        if (kind == KIND_RECORD) begin
          // Replace when empty, same key, or depth is close enough.
          new_rank = int'(search_depth) + ((bound_type == BOUND_EXACT) ? 1 : 0);
          old_rank = int'($signed(s.depth)) - 1;
          if (s.key == 64'd0 || s.key == position_hash || new_rank >= old_rank) begin
            s.key   = position_hash;
            s.depth = search_depth;
            s.bound = bound_type;
            s.score = result_score;
            s.move  = result_move;
            table_mirror[position_hash[IDX_W-1:0]] = s;
          end
        end else begin
          r = '0;
          if (s.key == position_hash) begin
            r.hit  = 1'b1;
            r.move = s.move;
            if ($signed(s.depth) >= search_depth) begin
              case (s.bound)
                BOUND_EXACT: begin
                  r.known = 1'b1;
                  r.score = s.score;
                end
                BOUND_UPPER: if ($signed(s.score) <= window_low) begin
                  r.known = 1'b1;
                  r.score = window_low;
                end
                BOUND_LOWER: if ($signed(s.score) >= window_high) begin
                  r.known = 1'b1;
                  r.score = window_high;
                end
                default: ;
              endcase
            end
          end
          replies_due.push_back(r);
        end
      end
    end
    mismatches <= mismatch_total;
    pending    <= replies_due.size();
  end

endmodule

### bench/tb_search_result_table_core.sv
// Top of the search result table bench: clock, reset, beat stimulus and the
// verdict. All checking lives in the probe checker instantiated below.
module tb_search_result_table_core;

  import srt_pkg::*;

  // The package names three bound codes; the fourth is legal input and must
  // be stored as given.
  localparam logic [1:0] BOUND_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               kind;
  logic [63:0]        position_hash;
  logic signed [7:0]  search_depth;
  logic signed [15:0] window_low;
  logic signed [15:0] window_high;
  logic [1:0]         bound_type;
  logic signed [15:0] result_score;
  logic [31:0]        result_move;
  logic               done;
  logic               key_hit;
  logic [31:0]        hit_move;
  logic               score_known;
  logic signed [15:0] probe_score;

  int mismatches;
  int pending;

  // Hashes already recorded; reusing them makes probes hit and records
  // land on occupied slots.
  logic [63:0] key_pool [$];

  logic               r_kind;
  logic [63:0]        r_hash;
  logic signed [7:0]  r_depth;
  logic signed [15:0] r_low;
  logic signed [15:0] r_high;
  logic [1:0]         r_bound;
  logic signed [15:0] r_score;
  int                 burst_left;
  int                 pick;

  always #6 clk = ~clk;

  search_result_table_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .position_hash (position_hash),
    .search_depth  (search_depth),
    .window_low    (window_low),
    .window_high   (window_high),
    .bound_type    (bound_type),
    .result_score  (result_score),
    .result_move   (result_move),
    .done          (done),
    .key_hit       (key_hit),
    .hit_move      (hit_move),
    .score_known   (score_known),
    .probe_score   (probe_score)
  );

  srt_probe_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .position_hash (position_hash),
    .search_depth  (search_depth),
    .window_low    (window_low),
    .window_high   (window_high),
    .bound_type    (bound_type),
    .result_score  (result_score),
    .result_move   (result_move),
    .done          (done),
    .key_hit       (key_hit),
    .hit_move      (hit_move),
    .score_known   (score_known),
    .probe_score   (probe_score),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // Present one beat and hold it until the block takes it. Returns on the
  // edge that accepted the beat, so the caller may drive the next one at once.
  task automatic send_beat(input logic k, input logic [63:0] h,
                           input logic signed [7:0] d,
                           input logic signed [15:0] lo, input logic signed [15:0] hi,
                           input logic [1:0] b, input logic signed [15:0] sc,
                           input logic [31:0] mv);
    start         <= 1'b1;
    kind          <= k;
    position_hash <= h;
    search_depth  <= d;
    window_low    <= lo;
    window_high   <= hi;
    bound_type    <= b;
    result_score  <= sc;
    result_move   <= mv;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Drop start and idle for a number of cycles.
  task automatic rest(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and hold off until every probe result has come back. The
  // checker's count is registered, so step the clock before looking at it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    kind          <= KIND_PROBE;
    position_hash <= 64'd0;
    search_depth  <= 8'sd0;
    window_low    <= 16'sd0;
    window_high   <= 16'sd0;
    bound_type    <= BOUND_EXACT;
    result_score  <= 16'sd0;
    result_move   <= 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed beats. The block sweeps its table after reset; send_beat
    // simply waits out busy.
    // Zero hash on an untouched slot hits the reset contents: stored depth
    // minus one against query depth minus one, upper bound at score zero.
    send_beat(KIND_PROBE, 64'd0, -8'sd1, 16'sd5, 16'sd10, BOUND_EXACT, 16'sd0, 32'd0);
    // Same slot, query one deeper: hit, but no score.
    send_beat(KIND_PROBE, 64'd0, 8'sd0, 16'sd5, 16'sd10, BOUND_EXACT, 16'sd0, 32'd0);
    // All-ones hash on an empty slot misses.
    send_beat(KIND_PROBE, '1, -8'sd128, 16'sh8000, 16'sh7fff, BOUND_EXACT, 16'sd0, 32'd0);
    // Fill the last slot at the extremes, then read it back.
    send_beat(KIND_RECORD, '1, 8'sd127, 16'sd0, 16'sd0, BOUND_EXACT, 16'sh7fff, '1);
    send_beat(KIND_PROBE, '1, 8'sd127, 16'sd0, 16'sd0, BOUND_EXACT, 16'sd0, 32'd0);
    send_beat(KIND_PROBE, '1, -8'sd128, 16'sh8000, 16'sh7fff, BOUND_UPPER, 16'sd0, 32'd0);
    // A shallow record of another key on that slot must be refused.
    send_beat(KIND_RECORD, 64'h8000_0000_0000_0fff, -8'sd128, 16'sd0, 16'sd0,
              BOUND_UPPER, 16'sd1, 32'h1234_5678);
    send_beat(KIND_PROBE, '1, 8'sd0, 16'sd0, 16'sd0, BOUND_EXACT, 16'sd0, 32'd0);
    // Depth exactly at the stored depth minus one replaces it.
    send_beat(KIND_RECORD, 64'h8000_0000_0000_0fff, 8'sd126, 16'sd0, 16'sd0,
              BOUND_LOWER, 16'sh8000, 32'd0);
    send_beat(KIND_PROBE, 64'h8000_0000_0000_0fff, 8'sd0, 16'sh8000, 16'sh8000,
              BOUND_EXACT, 16'sd0, 32'd0);
    // The unused bound code is stored; its probe hits without a score.
    send_beat(KIND_RECORD, 64'h123, 8'sd5, 16'sd0, 16'sd0, BOUND_UNUSED, 16'sd7,
              32'ha5a5_a5a5);
    send_beat(KIND_PROBE, 64'h123, 8'sd5, -16'sd100, 16'sd100, BOUND_EXACT, 16'sd0, 32'd0);
    // Upper bound: score equal to alpha settles, one above alpha does not.
    send_beat(KIND_RECORD, 64'h456, 8'sd3, 16'sd0, 16'sd0, BOUND_UPPER, -16'sd10,
              32'h0000_0456);
    send_beat(KIND_PROBE, 64'h456, 8'sd3, -16'sd10, 16'sd0, BOUND_EXACT, 16'sd0, 32'd0);
    send_beat(KIND_PROBE, 64'h456, 8'sd3, -16'sd11, 16'sd0, BOUND_EXACT, 16'sd0, 32'd0);
    send_beat(KIND_PROBE, 64'h456, 8'sd4, -16'sd10, 16'sd0, BOUND_EXACT, 16'sd0, 32'd0);
    // Inverted window is taken as given.
    send_beat(KIND_RECORD, 64'h789, 8'sd2, 16'sd0, 16'sd0, BOUND_LOWER, 16'sd50,
              32'h0000_0789);
    send_beat(KIND_PROBE, 64'h789, 8'sd2, 16'sd100, 16'sd20, BOUND_EXACT, 16'sd0, 32'd0);
    // Slot zero: replacement at the edge of the exact-score bonus, then a
    // record one step too shallow.
    send_beat(KIND_RECORD, 64'd0, 8'sd0, 16'sd0, 16'sd0, BOUND_EXACT, 16'sd1, 32'd1);
    send_beat(KIND_RECORD, 64'h1000, -8'sd2, 16'sd0, 16'sd0, BOUND_EXACT, 16'sd2, 32'd2);
    send_beat(KIND_RECORD, 64'h2000, -8'sd3, 16'sd0, 16'sd0, BOUND_UPPER, 16'sd3, 32'd3);
    send_beat(KIND_RECORD, 64'h3000, -8'sd5, 16'sd0, 16'sd0, BOUND_UPPER, 16'sd4, 32'd4);
    send_beat(KIND_PROBE, 64'h2000, -8'sd3, 16'sd3, 16'sd9, BOUND_EXACT, 16'sd0, 32'd0);
    send_beat(KIND_PROBE, 64'h3000, -8'sd5, 16'sd3, 16'sd9, BOUND_EXACT, 16'sd0, 32'd0);

    // Random beats in bursts. Most hashes fall on a handful of slots or
    // repeat a recorded key, so probes hit and records fight for slots.
    burst_left = 0;
    for (int n = 0; n < 1030; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 24));
      end
      burst_left--;
      // Hold off now and then until every result is back.
      if (n % 300 == 299) drain();

      r_kind = ($urandom_range(0, 99) < 55) ? KIND_PROBE : KIND_RECORD;
      pick = $urandom_range(0, 99);
      if (pick < 45 && key_pool.size() > 0)
        r_hash = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (pick < 80)
        r_hash = {$urandom, $urandom & 32'hffff_f000 | $urandom_range(0, 15)};
      else if (pick < 84)
        r_hash = 64'd0;
      else
        r_hash = {$urandom, $urandom};

      if ($urandom_range(0, 99) < 85) r_depth = 8'($urandom_range(0, 12) - 2);
      else r_depth = 8'($urandom);
      if ($urandom_range(0, 99) < 80) begin
        r_score = 16'($urandom_range(0, 40) - 20);
        r_low   = 16'($urandom_range(0, 40) - 20);
        r_high  = 16'($urandom_range(0, 40) - 20);
      end else begin
        r_score = 16'($urandom);
        r_low   = 16'($urandom);
        r_high  = 16'($urandom);
      end
      pick = $urandom_range(0, 99);
      r_bound = (pick < 30) ? BOUND_EXACT : (pick < 60) ? BOUND_UPPER :
                (pick < 90) ? BOUND_LOWER : BOUND_UNUSED;

      if (r_kind == KIND_RECORD) begin
        key_pool.push_back(r_hash);
        if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
      send_beat(r_kind, r_hash, r_depth, r_low, r_high, r_bound, r_score, $urandom);
    end

    // Let the last results come back, then a few cycles for strays.
    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop: the timeout covers the clearing sweep plus about a thousand
  // beats with gaps.
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
